### design/dhfk_pkg.sv
// Package for the DH forward kinematics chain: widths, CORDIC table, helpers.
// No dependencies.
package dhfk_pkg;

  localparam int ANGLE_BITS   = 16;
  localparam int ENTRY_BITS   = 24;
  localparam int FRAC_BITS    = 16;
  localparam int CORDIC_STEPS = 30;
  localparam int CW           = 34;  // CORDIC datapath width
  localparam int ACC_W        = 64;  // accumulator width

  typedef logic signed [ENTRY_BITS-1:0] entry_t;

  // Arctangent table, 2^32 per full turn.
  function automatic logic signed [CW-1:0] atan_val(input logic [4:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0:  v = 32'h20000000; 5'd1:  v = 32'h12E4051E; 5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4; 5'd4:  v = 32'h028B0D43; 5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E; 5'd7:  v = 32'h00517C55; 5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F; 5'd10: v = 32'h000A2F98; 5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6; 5'd13: v = 32'h000145F3; 5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D; 5'd16: v = 32'h000028BE; 5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30; 5'd19: v = 32'h00000518; 5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146; 5'd22: v = 32'h000000A3; 5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029; 5'd25: v = 32'h00000014; 5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005; 5'd28: v = 32'h00000003; 5'd29: v = 32'h00000001;
      default: v = 32'h0;
    endcase
    return $signed({2'b00, v});
  endfunction

  // Round half up at FRAC_BITS, then clamp to the entry range.
  function automatic entry_t round_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] r;
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = (ACC_W'(1) <<< (ENTRY_BITS - 1)) - ACC_W'(1);
    lo = -hi - ACC_W'(1);
    r  = (acc + (ACC_W'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    if (r > hi) r = hi;
    else if (r < lo) r = lo;
    return r[ENTRY_BITS-1:0];
  endfunction

endpackage

### design/dhfk_cordic.sv
// Iterative CORDIC: one rotation step per cycle, sine and cosine of a binary angle.
// Depends on dhfk_pkg.
module dhfk_cordic (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic [dhfk_pkg::ANGLE_BITS-1:0]       angle,
  output logic                                  done,
  output logic signed [dhfk_pkg::FRAC_BITS+1:0] sin_out,
  output logic signed [dhfk_pkg::FRAC_BITS+1:0] cos_out
);

  logic signed [dhfk_pkg::CW-1:0] x, y, z;
  logic [4:0] step;
  logic       busy;
  logic       flip;

  logic [31:0] p;
  logic        fl;
  logic signed [dhfk_pkg::CW-1:0] dx, dy, xr, yr;

  always_comb begin
    p  = {angle, {(32 - dhfk_pkg::ANGLE_BITS){1'b0}}};
    fl = (p >= 32'h40000000) && (p < 32'hC0000000);
    if (fl) p = p + 32'h80000000;
    dx = y >>> step;
    dy = x >>> step;
    xr = (x + (dhfk_pkg::CW'(1) <<< (29 - dhfk_pkg::FRAC_BITS))) >>> (30 - dhfk_pkg::FRAC_BITS);
    yr = (y + (dhfk_pkg::CW'(1) <<< (29 - dhfk_pkg::FRAC_BITS))) >>> (30 - dhfk_pkg::FRAC_BITS);
  end

  // Rotation sequencer.
  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      x    <= dhfk_pkg::CW'(652032874);
      y    <= '0;
      z    <= dhfk_pkg::CW'($signed(p));
      flip <= fl;
      step <= '0;
      busy <= 1'b1;
    end else if (busy) begin
      if (z >= 0) begin
        x <= x - dx; y <= y + dy; z <= z - dhfk_pkg::atan_val(step);
      end else begin
        x <= x + dx; y <= y - dy; z <= z + dhfk_pkg::atan_val(step);
      end
      if (step == 5'(dhfk_pkg::CORDIC_STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
      step <= step + 5'd1;
    end
  end

  assign cos_out = flip ? -xr[dhfk_pkg::FRAC_BITS+1:0] : xr[dhfk_pkg::FRAC_BITS+1:0];
  assign sin_out = flip ? -yr[dhfk_pkg::FRAC_BITS+1:0] : yr[dhfk_pkg::FRAC_BITS+1:0];

endmodule

### design/dh_forward_kinematics_chain.sv
// DH forward kinematics chain top level. Depends on dhfk_pkg and dhfk_cordic.
// An accepted joint passes through two 30-step CORDIC runs, six link products and
// 36 multiply-accumulates on one shared multiplier before its first row appears.
// Rows 1 and 2 follow one per cycle while m_tready is high.
// A new joint is accepted only after the last row of the previous one is taken.
// Reset (synchronous, rst high) sets the cumulative transform to identity.
module dh_forward_kinematics_chain (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // joint_position[15:0], joint_offset[31:16], link_length[51:32],
  // link_twist[67:52], link_offset[87:68], zero pad [95:88]
  input  logic [95:0] s_tdata,
  // reverse_sense[0], first_joint[1]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // row_index[1:0], entry_col0[25:2], entry_col1[49:26], entry_col2[73:50],
  // entry_col3[97:74], zero pad [103:98]
  output logic [103:0] m_tdata,
  output logic        m_tlast
);

  localparam logic [2:0] S_IDLE = 3'd0, S_CT = 3'd1, S_CA = 3'd2, S_LM = 3'd3,
                         S_MAC = 3'd4, S_OUT = 3'd5;
  localparam int FB = dhfk_pkg::FRAC_BITS;

  logic [2:0] state;
  logic [15:0] tw;
  logic signed [19:0] a_l, d_l;
  logic first;
  dhfk_pkg::entry_t ct [3][4];
  logic signed [FB+1:0] cth, sth, cal, sal;
  logic signed [dhfk_pkg::ENTRY_BITS-1:0] lm [3][4];
  logic [3:0] idx;  // link product or output entry index
  logic [1:0] kk, orow;
  logic signed [dhfk_pkg::ACC_W-1:0] acc;
  dhfk_pkg::entry_t nt [3][4];

  logic cstart, cdone;
  logic [dhfk_pkg::ANGLE_BITS-1:0] cang;
  logic signed [FB+1:0] csin, ccos;

  dhfk_cordic u_cordic (
    .clk(clk), .rst(rst), .start(cstart), .angle(cang),
    .done(cdone), .sin_out(csin), .cos_out(ccos)
  );

  // Shared multiplier operands.
  logic signed [31:0] ma, mb;
  logic signed [63:0] prod;
  logic [1:0] r_i, c_i;
  always_comb begin
    r_i = idx[3:2];
    c_i = idx[1:0];
    ma = '0; mb = '0;
    if (state == S_LM) begin
      unique case (idx)
        4'd0: begin ma = 32'(sth); mb = 32'(cal); end
        4'd1: begin ma = 32'(sth); mb = 32'(sal); end
        4'd2: begin ma = 32'(cth); mb = 32'(cal); end
        4'd3: begin ma = 32'(cth); mb = 32'(sal); end
        4'd4: begin ma = 32'(a_l); mb = 32'(cth); end
        default: begin ma = 32'(a_l); mb = 32'(sth); end
      endcase
    end else begin
      ma = 32'(ct[r_i][kk]);
      mb = 32'(lm[kk][c_i]);
    end
    prod = ma * mb;
  end

  logic signed [63:0] prnd;
  assign prnd = (prod + (64'sd1 <<< (FB - 1))) >>> FB;

  assign cstart = (state == S_IDLE && s_tvalid) || (state == S_CT && cdone);
  always_comb begin
    logic [15:0] pp;
    pp = s_tuser[0] ? -s_tdata[15:0] : s_tdata[15:0];
    cang = (state == S_IDLE) ? pp + s_tdata[31:16] : tw;
  end

  assign s_tready = (state == S_IDLE);

  // Main sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 4; c++)
          ct[r][c] <= (r == c) ? dhfk_pkg::ENTRY_BITS'(1 << FB) : '0;
    end else begin
      unique case (state)
        S_IDLE: if (s_tvalid) begin
          tw <= s_tdata[67:52]; a_l <= s_tdata[51:32]; d_l <= s_tdata[87:68];
          first <= s_tuser[1];
          state <= S_CT;
        end
        S_CT: if (cdone) begin
          cth <= ccos; sth <= csin;
          state <= S_CA;
        end
        S_CA: if (cdone) begin
          cal <= ccos; sal <= csin;
          idx <= '0;
          state <= S_LM;
          if (first)
            for (int r = 0; r < 3; r++)
              for (int c = 0; c < 4; c++)
                ct[r][c] <= (r == c) ? dhfk_pkg::ENTRY_BITS'(1 << FB) : '0;
        end
        S_LM: begin
          unique case (idx)
            4'd0: lm[0][1] <= -prnd[dhfk_pkg::ENTRY_BITS-1:0];
            4'd1: lm[0][2] <= prnd[dhfk_pkg::ENTRY_BITS-1:0];
            4'd2: lm[1][1] <= prnd[dhfk_pkg::ENTRY_BITS-1:0];
            4'd3: lm[1][2] <= -prnd[dhfk_pkg::ENTRY_BITS-1:0];
            4'd4: lm[0][3] <= prnd[dhfk_pkg::ENTRY_BITS-1:0];
            default: lm[1][3] <= prnd[dhfk_pkg::ENTRY_BITS-1:0];
          endcase
          lm[0][0] <= dhfk_pkg::ENTRY_BITS'(cth);
          lm[1][0] <= dhfk_pkg::ENTRY_BITS'(sth);
          lm[2][0] <= '0;
          lm[2][1] <= dhfk_pkg::ENTRY_BITS'(sal);
          lm[2][2] <= dhfk_pkg::ENTRY_BITS'(cal);
          lm[2][3] <= dhfk_pkg::ENTRY_BITS'(d_l);
          if (idx == 4'd5) begin
            idx <= '0; kk <= '0; acc <= '0;
            state <= S_MAC;
          end else begin
            idx <= idx + 4'd1;
          end
        end
        S_MAC: begin
          // Three products per entry; the translation column adds the kept offset.
          if (kk == 2'd2) begin
            logic signed [63:0] s;
            s = acc + prod;
            if (c_i == 2'd3) s = s + (64'(ct[r_i][3]) <<< FB);
            nt[r_i][c_i] <= dhfk_pkg::round_sat(s);
            kk <= '0; acc <= '0;
            if (idx == 4'd11) begin
              orow <= '0;
              state <= S_OUT;
            end
            idx <= idx + 4'd1;
          end else begin
            acc <= acc + prod;
            kk <= kk + 2'd1;
          end
        end
        S_OUT: begin
          if (orow == 2'd0) ct <= nt;
          if (m_tready) begin
            if (orow == 2'd2) state <= S_IDLE;
            orow <= orow + 2'd1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_tvalid = (state == S_OUT);
  assign m_tlast  = (orow == 2'd2);
  assign m_tdata  = {6'd0, nt[orow][3], nt[orow][2], nt[orow][1], nt[orow][0], orow};

  a_out_rows: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> orow != 2'd3) else $error("row index out of range");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !s_tready) else $error("ready while busy");
  a_last_done: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> state == S_IDLE) else $error("no return to idle");

endmodule

### sim/dh_forward_kinematics_chain_tb.sv
// Testbench for the DH forward kinematics chain: joints go in on the slave stream and
// three rows of the cumulative transform come out on the master stream. Each row is
// checked against an in-bench CORDIC and matrix predictor. Depends on dhfk_pkg and dh_forward_kinematics_chain.
`timescale 1ns / 100ps

module dh_forward_kinematics_chain_tb;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [95:0]  s_tdata;   // joint_position, joint_offset, link_length, link_twist,
                           // link_offset, zero pad
  logic [1:0]   s_tuser;   // reverse_sense, first_joint
  logic         m_tvalid;
  logic         m_tready;
  logic [103:0] m_tdata;   // row_index, entry_col0..entry_col3, zero pad
  logic         m_tlast;

  typedef struct packed {
    logic [1:0]  row;
    logic [23:0] col0;
    logic [23:0] col1;
    logic [23:0] col2;
    logic [23:0] col3;
    logic        last;
  } row_item_t;

  row_item_t   expected_rows[$];
  longint      chain_xform[3][4];
  int          mismatch_count;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  dh_forward_kinematics_chain dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Arctangent steps, 2^32 per full turn.
  function automatic longint atan_step(input int i);
    longint steps[30] = '{
      'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43,
      'h0145D7E1, 'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F,
      'h000A2F98, 'h000517CC, 'h00028BE6, 'h000145F3, 'h0000A2FA,
      'h0000517D, 'h000028BE, 'h0000145F, 'h00000A30, 'h00000518,
      'h0000028C, 'h00000146, 'h000000A3, 'h00000051, 'h00000029,
      'h00000014, 'h0000000A, 'h00000005, 'h00000003, 'h00000001};
    return steps[i];
  endfunction

  // Sine and cosine of a 16-bit binary angle, FRAC_BITS fraction bits.
  function automatic void angle_sin_cos(input logic [15:0] ang, output longint s,
                                        output longint c);
    logic [31:0] p;
    logic        flip;
    longint      x, y, z, dx, dy;
    p = {ang, 16'h0000};
    flip = 1'b0;
    x = 652032874;
    y = 0;
    if (p >= 32'h40000000 && p < 32'hC0000000) begin
      p = p + 32'h80000000;
      flip = 1'b1;
    end
    z = longint'($signed(p));
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_step(i);
      end else begin
        x += dx; y -= dy; z += atan_step(i);
      end
    end
    x = (x + (longint'(1) << 13)) >>> 14;
    y = (y + (longint'(1) << 13)) >>> 14;
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint fix_mul(input longint a, input longint b);
    return (a * b + (longint'(1) << (dhfk_pkg::FRAC_BITS - 1))) >>> dhfk_pkg::FRAC_BITS;
  endfunction

  function automatic void reset_chain();
    for (int r = 0; r < 3; r++)
      for (int k = 0; k < 4; k++)
        chain_xform[r][k] = (r == k) ? (longint'(1) << dhfk_pkg::FRAC_BITS) : 0;
  endfunction

  // Applies one joint to the kept transform and queues the three rows it yields.
  function automatic void predict_joint_rows(input logic [95:0] data, input logic [1:0] user);
    longint    pos, ct, st, ca, sa, acc, hi;
    longint    link[3][4];
    longint    prod[3][4];
    row_item_t item;
    pos = longint'($signed(data[15:0]));
    if (user[0]) pos = -pos;
    angle_sin_cos(16'(pos + longint'($signed(data[31:16]))), st, ct);
    angle_sin_cos(data[67:52], sa, ca);
    link[0][0] = ct; link[0][1] = -fix_mul(st, ca); link[0][2] = fix_mul(st, sa);
    link[1][0] = st; link[1][1] = fix_mul(ct, ca);  link[1][2] = -fix_mul(ct, sa);
    link[2][0] = 0;  link[2][1] = sa;               link[2][2] = ca;
    link[0][3] = fix_mul(longint'($signed(data[51:32])), ct);
    link[1][3] = fix_mul(longint'($signed(data[51:32])), st);
    link[2][3] = longint'($signed(data[87:68]));
    if (user[1]) reset_chain();
    hi = (longint'(1) << (dhfk_pkg::ENTRY_BITS - 1)) - 1;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 4; c++) begin
        acc = 0;
        for (int k = 0; k < 3; k++) acc += chain_xform[r][k] * link[k][c];
        if (c == 3) acc += chain_xform[r][3] * (longint'(1) << dhfk_pkg::FRAC_BITS);
        acc = (acc + (longint'(1) << (dhfk_pkg::FRAC_BITS - 1))) >>> dhfk_pkg::FRAC_BITS;
        prod[r][c] = acc > hi ? hi : (acc < -hi - 1 ? -hi - 1 : acc);
      end
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 4; c++) chain_xform[r][c] = prod[r][c];
      item.row  = 2'(r);
      item.col0 = 24'(prod[r][0]);
      item.col1 = 24'(prod[r][1]);
      item.col2 = 24'(prod[r][2]);
      item.col3 = 24'(prod[r][3]);
      item.last = (r == 2);
      expected_rows.push_back(item);
    end
  endfunction

  task automatic report_mismatch(input string field, input longint got, input longint want);
    $display("mismatch at %0t: %s got %h expected %h", $realtime, field, got, want);
    mismatch_count++;
  endtask

  // Sends one joint item and waits until it is accepted.
  task automatic send_joint(input logic [15:0] pos, input logic [15:0] off, input logic rev,
                            input logic [19:0] a, input logic [15:0] tw, input logic [19:0] d,
                            input logic first);
    logic [95:0] data;
    data = {8'h00, d, tw, a, off, pos};
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    predict_joint_rows(data, {first, rev});
    s_tvalid <= 1'b1;
    s_tdata  <= data;
    s_tuser  <= {first, rev};
    do @(posedge clk); while (!s_tready);
  endtask

  // Receiver side stalls at random.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Each accepted row is compared with the oldest expected row.
  always @(posedge clk) begin
    row_item_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_rows.size() == 0) begin
        $display("unexpected row at %0t: %h", $realtime, m_tdata);
        mismatch_count++;
      end else begin
        want = expected_rows.pop_front();
        if (m_tdata[1:0] != want.row) report_mismatch("row_index", m_tdata[1:0], want.row);
        if (m_tdata[25:2] != want.col0) report_mismatch("entry_col0", m_tdata[25:2], want.col0);
        if (m_tdata[49:26] != want.col1)
          report_mismatch("entry_col1", m_tdata[49:26], want.col1);
        if (m_tdata[73:50] != want.col2)
          report_mismatch("entry_col2", m_tdata[73:50], want.col2);
        if (m_tdata[97:74] != want.col3)
          report_mismatch("entry_col3", m_tdata[97:74], want.col3);
        if (m_tdata[103:98] != 6'd0) report_mismatch("pad", m_tdata[103:98], 0);
        if (m_tlast != want.last) report_mismatch("last_row", m_tlast, want.last);
      end
    end
  end

  // Field extremes, quarter turns, angle wrap, reverse sense and chain restart.
  task automatic test_directed();
    send_joint(16'h0000, 16'h0000, 1'b0, 20'h00000, 16'h0000, 20'h00000, 1'b0);
    send_joint(16'h8000, 16'h0000, 1'b0, 20'h7FFFF, 16'h7FFF, 20'h80000, 1'b1);
    send_joint(16'h7FFF, 16'h7FFF, 1'b0, 20'h80000, 16'h8000, 20'h7FFFF, 1'b1);
    send_joint(16'h8000, 16'h0000, 1'b1, 20'h10000, 16'h4000, 20'h10000, 1'b0);
    send_joint(16'h4000, 16'h0000, 1'b0, 20'h10000, 16'hC000, 20'hF0000, 1'b0);
    send_joint(16'h4000, 16'h4000, 1'b1, 20'h08000, 16'h2000, 20'h00000, 1'b0);
    send_joint(16'hC000, 16'h8000, 1'b0, 20'hF8000, 16'hE000, 20'h04000, 1'b0);
    send_joint(16'h7FFF, 16'h0001, 1'b0, 20'h00001, 16'h0001, 20'hFFFFF, 1'b0);
    send_joint(16'hFFFF, 16'hFFFF, 1'b1, 20'hFFFFF, 16'hFFFF, 20'h00001, 1'b1);
    send_joint(16'h2000, 16'h6000, 1'b0, 20'h20000, 16'h0000, 20'h30000, 1'b1);
  endtask

  // Long links chained after one restart drive the translation column into saturation.
  task automatic test_saturation();
    send_joint(16'h0000, 16'h0000, 1'b0, 20'h7FFFF, 16'h0000, 20'h80000, 1'b1);
    for (int i = 0; i < 20; i++)
      send_joint(16'h0000, 16'h0000, 1'b0, 20'h7FFFF, 16'h0000, 20'h80000, 1'b0);
  endtask

  // Random chains that start with a restart, mixed with fully random joints.
  task automatic test_random_chains(input int joints);
    int left;
    int sent;
    logic [19:0] a, d;
    sent = 0;
    while (sent < joints) begin
      left = $urandom_range(1, 8);
      for (int j = 0; j < left && sent < joints; j++) begin
        a = $urandom_range(0, 3) == 0 ? 20'($urandom) : 20'($signed(18'($urandom)));
        d = $urandom_range(0, 3) == 0 ? 20'($urandom) : 20'($signed(18'($urandom)));
        if ($urandom_range(0, 9) == 0)
          send_joint(16'($urandom), 16'($urandom), 1'($urandom), 20'($urandom),
                     16'($urandom), 20'($urandom), 1'($urandom));
        else
          send_joint(16'($urandom), 16'($urandom), 1'($urandom), a,
                     16'($urandom), d, j == 0);
        sent++;
      end
    end
  endtask

  initial begin
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    s_tuser        = '0;
    m_tready       = 1'b0;
    mismatch_count = 0;
    send_idle_pct  = 32;
    recv_stall_pct = 75;
    reset_chain();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_saturation();
    test_random_chains(63);
    send_idle_pct  = 75;
    recv_stall_pct = 32;
    test_random_chains(63);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_chains(63);
    s_tvalid <= 1'b0;

    // Drain the remaining rows, then let the block settle.
    for (int n = 0; n < 20000 && expected_rows.size() != 0; n++) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatch_count == 0 && expected_rows.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Run limit, well above the slowest correct run.
  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end

endmodule
